// ----- sv/selt_pkg.sv -----
// ----------------------------------------------------------------------------
// SSG envelope level translator package
// Shared payload types, register numbers and envelope tables.
// ----------------------------------------------------------------------------
package selt_pkg;

    typedef struct packed {
        logic       action;
        logic [3:0] reg_addr;
        logic [7:0] reg_data;
    } ssg_in_t;

    typedef struct packed {
        logic [6:0] opm_register;
        logic [6:0] opm_value;
        logic       last_of_run;
    } ssg_out_t;

    typedef enum logic [1:0] {
        SEG_UP       = 2'd0,
        SEG_DOWN     = 2'd1,
        SEG_HOLD_BOT = 2'd2,
        SEG_HOLD_TOP = 2'd3
    } seg_kind_t;

    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    localparam logic [3:0] CFG_CHIP_MODE = 4'd0;
    localparam logic [3:0] CFG_MAP_A     = 4'd1;
    localparam logic [3:0] CFG_MAP_B     = 4'd2;
    localparam logic [3:0] CFG_MAP_C     = 4'd3;

    localparam logic [3:0] REG_TONE_FIRST = 4'd0;
    localparam logic [3:0] REG_TONE_LAST  = 4'd5;
    localparam logic [3:0] REG_MIXER      = 4'd7;
    localparam logic [3:0] REG_LEVEL_A    = 4'd8;
    localparam logic [3:0] REG_LEVEL_C    = 4'd10;
    localparam logic [3:0] REG_ENV_FINE   = 4'd11;
    localparam logic [3:0] REG_ENV_COARSE = 4'd12;
    localparam logic [3:0] REG_ENV_SHAPE  = 4'd13;

    localparam logic [6:0] TL_REG_BASE = 7'h70;
    localparam logic [6:0] TL_SILENT   = 7'h7f;
    localparam logic [7:0] TL_OFFSET   = 8'd3;
    localparam logic [4:0] LEVEL_TOP   = 5'd31;
    localparam int         MAX_RES     = 6;

    localparam logic [6:0] VOL_TL [16] = '{
        7'd127, 7'd62, 7'd56, 7'd52, 7'd46, 7'd42, 7'd36, 7'd32,
        7'd28,  7'd24, 7'd20, 7'd16, 7'd12, 7'd8,  7'd4,  7'd0
    };

    function automatic seg_kind_t seg_kind(input logic [3:0] shape, input logic seg);
        seg_kind_t k;
        k = SEG_HOLD_BOT;
        case (shape)
            4'd0, 4'd1, 4'd2, 4'd3: k = seg ? SEG_HOLD_BOT : SEG_DOWN;
            4'd4, 4'd5, 4'd6, 4'd7: k = seg ? SEG_HOLD_BOT : SEG_UP;
            4'd8:                   k = SEG_DOWN;
            4'd9:                   k = seg ? SEG_HOLD_BOT : SEG_DOWN;
            4'd10:                  k = seg ? SEG_UP : SEG_DOWN;
            4'd11:                  k = seg ? SEG_HOLD_TOP : SEG_DOWN;
            4'd12:                  k = SEG_UP;
            4'd13:                  k = seg ? SEG_HOLD_TOP : SEG_UP;
            4'd14:                  k = seg ? SEG_DOWN : SEG_UP;
            default:                k = seg ? SEG_HOLD_BOT : SEG_UP;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] reload_level(input logic [3:0] shape, input logic seg);
        seg_kind_t k;
        k = seg_kind(shape, seg);
        return (k == SEG_DOWN || k == SEG_HOLD_TOP) ? LEVEL_TOP : 5'd0;
    endfunction

    function automatic logic [6:0] tl_value(input logic silent, input logic [7:0] vreg,
                                            input logic [4:0] lvl);
        logic [3:0] vol;
        logic [7:0] sum;
        vol = vreg[4] ? lvl[4:1] : vreg[3:0];
        sum = {1'b0, VOL_TL[vol]} + TL_OFFSET;
        if (silent) begin
            return TL_SILENT;
        end
        return (sum > {1'b0, TL_SILENT}) ? TL_SILENT : sum[6:0];
    endfunction

endpackage

// ----- sv/ssg_envelope_level_translator.sv -----
// ----------------------------------------------------------------------------
// SSG envelope level translator
// Keeps the SSG register file and envelope state and emits total-level writes.
// ----------------------------------------------------------------------------
// Flow: an accepted beat is registered in item_reg and processed into the
// result buffer once that buffer is empty or its last result is taken.
// Throughput: one input beat per cycle when it yields at most one result and
// out_stall stays low; else it waits while the single result port drains.
// Reset: asynchronous active-low, clears registers, envelope and config.
// ----------------------------------------------------------------------------
module ssg_envelope_level_translator (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [3:0]           cfg_index,
    input  logic [3:0]           cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  selt_pkg::ssg_in_t    in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output selt_pkg::ssg_out_t   out_data
);

    logic               chip_mode_reg;
    logic [3:0]         map_reg [3];
    logic [7:0]         regs_reg [16];
    logic [7:0]         regs_new [16];
    logic [15:0]        count_reg, count_next, count_inc;
    logic [15:0]        period_reg, period_next, period_raw;
    logic [3:0]         shape_reg, shape_next;
    logic               seg_reg, seg_next;
    logic [4:0]         level_reg, level_next, level_run;
    logic               in_valid_reg;
    selt_pkg::ssg_in_t  item_reg;
    selt_pkg::ssg_out_t res_reg [selt_pkg::MAX_RES];
    selt_pkg::ssg_out_t res_next [selt_pkg::MAX_RES];
    logic [2:0]         n_reg, n_next, idx_reg;
    logic               accept, proc, pop, last_pop;
    logic               mapped [3];
    logic [2:0]         tgt [3];
    logic               cand_en [selt_pkg::MAX_RES];
    logic [1:0]         cand_ch [selt_pkg::MAX_RES];
    logic [4:0]         cand_lvl [selt_pkg::MAX_RES];
    logic               shape_ok, restarted;
    logic               silent;
    logic [1:0]         ch_w;

    assign cfg_ready = 1'b1;
    assign out_valid = (n_reg != 3'd0);
    assign out_data  = res_reg[idx_reg];
    assign pop       = out_valid && !out_stall;
    assign last_pop  = pop && (idx_reg == n_reg - 3'd1);
    assign proc      = in_valid_reg && (!out_valid || last_pop);
    assign in_stall  = in_valid_reg && !proc;
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            if (!chip_mode_reg)
            begin
                mapped[c] = 1'b1;
                tgt[c]    = 3'(c + 3);
            end
            else
            begin
                mapped[c] = !map_reg[c][3];
                tgt[c]    = map_reg[c][2:0];
            end
        end
    end

    always_comb
    begin
        regs_new = regs_reg;
        if (item_reg.action == selt_pkg::ACT_WRITE)
        begin
            regs_new[item_reg.reg_addr] = item_reg.reg_data;
        end
        count_next  = count_reg;
        period_next = period_reg;
        shape_next  = shape_reg;
        seg_next    = seg_reg;
        level_next  = level_reg;
        level_run   = level_reg;
        restarted   = 1'b0;
        count_inc   = count_reg + 16'd1;
        period_raw  = {regs_new[selt_pkg::REG_ENV_COARSE], regs_new[selt_pkg::REG_ENV_FINE]};
        shape_ok    = !shape_reg[3] || shape_reg == 4'd9 || shape_reg == 4'd11;
        ch_w        = 2'd0;
        for (int i = 0; i < selt_pkg::MAX_RES; i++)
        begin
            cand_en[i]  = 1'b0;
            cand_ch[i]  = 2'(i % 3);
            cand_lvl[i] = level_reg;
        end

        if (item_reg.action == selt_pkg::ACT_TICK)
        begin
            if (count_inc < period_reg)
            begin
                count_next = count_inc;
            end
            else
            begin
                count_next = 16'd0;
                case (selt_pkg::seg_kind(shape_reg, seg_reg))
                    selt_pkg::SEG_UP:
                    begin
                        if (level_reg >= selt_pkg::LEVEL_TOP)
                        begin
                            seg_next   = !seg_reg;
                            level_next = selt_pkg::reload_level(shape_reg, !seg_reg);
                        end
                        else
                        begin
                            level_next = level_reg + 5'd1;
                        end
                    end
                    selt_pkg::SEG_DOWN:
                    begin
                        if (level_reg == 5'd0)
                        begin
                            seg_next   = !seg_reg;
                            level_next = selt_pkg::reload_level(shape_reg, !seg_reg);
                        end
                        else
                        begin
                            level_next = level_reg - 5'd1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                for (int c = 0; c < 3; c++)
                begin
                    cand_en[c]  = regs_new[8 + c][4] && mapped[c];
                    cand_lvl[c] = level_next;
                end
            end
        end
        else
        begin
            case (item_reg.reg_addr) inside
                [selt_pkg::REG_TONE_FIRST:selt_pkg::REG_TONE_LAST]:
                begin
                    ch_w        = item_reg.reg_addr[2:1];
                    cand_en[0]  = mapped[ch_w];
                    cand_ch[0]  = ch_w;
                    if (regs_new[{2'b10, ch_w}][4] && shape_ok)
                    begin
                        count_next = 16'd0;
                        seg_next   = 1'b0;
                        level_next = selt_pkg::reload_level(shape_reg, 1'b0);
                    end
                end
                [selt_pkg::REG_LEVEL_A:selt_pkg::REG_LEVEL_C]:
                begin
                    cand_en[0] = mapped[item_reg.reg_addr[1:0]];
                    cand_ch[0] = item_reg.reg_addr[1:0];
                end
                selt_pkg::REG_MIXER:
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        cand_lvl[c] = level_run;
                        if (!item_reg.reg_data[c] && regs_reg[selt_pkg::REG_MIXER][c]
                            && mapped[c])
                        begin
                            cand_en[c] = 1'b1;
                            if (regs_new[8 + c][4] && shape_ok)
                            begin
                                restarted = 1'b1;
                                level_run = selt_pkg::reload_level(shape_reg, 1'b0);
                            end
                        end
                    end
                    for (int c = 0; c < 3; c++)
                    begin
                        cand_en[c + 3]  = mapped[c];
                        cand_lvl[c + 3] = level_run;
                    end
                    if (restarted)
                    begin
                        count_next = 16'd0;
                        seg_next   = 1'b0;
                        level_next = level_run;
                    end
                end
                selt_pkg::REG_ENV_FINE, selt_pkg::REG_ENV_COARSE:
                begin
                    period_next = (period_raw == 16'd0) ? 16'd1 : period_raw;
                end
                selt_pkg::REG_ENV_SHAPE:
                begin
                    shape_next = item_reg.reg_data[3:0];
                    count_next = 16'd0;
                    seg_next   = 1'b0;
                    level_next = selt_pkg::reload_level(item_reg.reg_data[3:0], 1'b0);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        n_next = 3'd0;
        silent = 1'b0;
        for (int i = 0; i < selt_pkg::MAX_RES; i++)
        begin
            res_next[i] = res_reg[i];
        end
        for (int i = 0; i < selt_pkg::MAX_RES; i++)
        begin
            silent = regs_new[selt_pkg::REG_MIXER][{1'b0, cand_ch[i]}]
                || (!chip_mode_reg && !regs_new[selt_pkg::REG_MIXER][{1'b0, cand_ch[i]} + 3'd3]);
            if (cand_en[i])
            begin
                res_next[n_next].opm_register = selt_pkg::TL_REG_BASE | {4'd0, tgt[cand_ch[i]]};
                res_next[n_next].opm_value    = selt_pkg::tl_value(silent,
                                                    regs_new[{2'b10, cand_ch[i]}], cand_lvl[i]);
                res_next[n_next].last_of_run  = 1'b0;
                n_next = n_next + 3'd1;
            end
        end
        if (n_next != 3'd0)
        begin
            res_next[n_next - 3'd1].last_of_run = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chip_mode_reg <= 1'b0;
            for (int c = 0; c < 3; c++)
            begin
                map_reg[c] <= 4'hf;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                selt_pkg::CFG_CHIP_MODE: chip_mode_reg <= cfg_data[0];
                selt_pkg::CFG_MAP_A:     map_reg[0]    <= cfg_data;
                selt_pkg::CFG_MAP_B:     map_reg[1]    <= cfg_data;
                selt_pkg::CFG_MAP_C:     map_reg[2]    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 16; r++)
            begin
                regs_reg[r] <= 8'd0;
            end
            count_reg  <= 16'd0;
            period_reg <= 16'd1;
            shape_reg  <= 4'd0;
            seg_reg    <= 1'b0;
            level_reg  <= 5'd0;
        end
        else if (proc)
        begin
            regs_reg   <= regs_new;
            count_reg  <= count_next;
            period_reg <= period_next;
            shape_reg  <= shape_next;
            seg_reg    <= seg_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (proc)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_data;
        end
        if (proc)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg   <= 3'd0;
            idx_reg <= 3'd0;
        end
        else if (proc)
        begin
            n_reg   <= n_next;
            idx_reg <= 3'd0;
        end
        else if (last_pop)
        begin
            n_reg   <= 3'd0;
            idx_reg <= 3'd0;
        end
        else if (pop)
        begin
            idx_reg <= idx_reg + 3'd1;
        end
    end

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (n_reg != 3'd0) |-> (idx_reg < n_reg && n_reg <= 3'(selt_pkg::MAX_RES)))
        else $error("result index outside buffered run");

    a_period_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        period_reg != 16'd0)
        else $error("envelope period is zero");

    a_no_step_holds_level: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && item_reg.action == selt_pkg::ACT_TICK && count_inc < period_reg)
        |=> $stable(level_reg))
        else $error("envelope level moved on a tick without a step");

endmodule
